@@ hw/rtl/interval_set_engine_assert.svh @@
// Assertion macros shared by the checkers of the interval set engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INTERVAL_SET_ENGINE_ASSERT_SVH
`define INTERVAL_SET_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("interval set engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("interval set engine check failed");

`endif

@@ hw/rtl/ise_pkg.sv @@
package ise_pkg;

  // Set geometry.
  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  // Fixed port field widths.
  localparam int ACT_W    = 3;
  localparam int FIELD_W  = 32;
  localparam int EIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int RCOUNT_W = 5;

  // Derived widths.
  localparam int VW     = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW     = $clog2(CAPACITY + 2);
  localparam int CMP_W  = (NW > EIDX_W) ? NW : EIDX_W;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COVERS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_OVERLAP = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef logic [VW-1:0] value_t;

endpackage

@@ hw/rtl/interval_set_engine.sv @@
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | action, range_low, range_high, entry_index
// out_    | output    | out_valid/out_stall| status, range_count, entry_low, entry_high, hit
//
// Operation: one shared compare unit walks the stored ranges, a memory read and then
// an evaluate step for each range. An add runs a merge scan and then a rebuild scan,
// a remove and a query one scan each, and a read looks up the entry it names. The
// single read port of the range memory sets the pace of the scans.
// Reset: synchronous, active low; it empties the set, the memory is not cleared.
// Stalls: in_stall is high while an item is at work; a finished result waits in the
// output register while out_stall is high, and the next item may already be taken.
module interval_set_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ise_pkg::ACT_W-1:0]      in_action,
  input  logic [ise_pkg::FIELD_W-1:0]    in_range_low,
  input  logic [ise_pkg::FIELD_W-1:0]    in_range_high,
  input  logic [ise_pkg::EIDX_W-1:0]     in_entry_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ise_pkg::STATUS_W-1:0]   out_status,
  output logic [ise_pkg::RCOUNT_W-1:0]   out_range_count,
  output logic [ise_pkg::FIELD_W-1:0]    out_entry_low,
  output logic [ise_pkg::FIELD_W-1:0]    out_entry_high,
  output logic                           out_hit
);
  import ise_pkg::*;

  // The range memory holds two banks: the live set is read from one bank while
  // an add or remove builds the new set in the other. A successful update then
  // just flips the bank, and a refused one leaves the live bank untouched.
  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EX, S_W2, S_FIN, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic                  bank_r, bank_nxt;
  logic [NW-1:0]         count_r, count_nxt;
  logic [ACT_W-1:0]      op_r, op_nxt;
  logic                  phase_r, phase_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  value_t                a_lo_r, a_lo_nxt, a_hi_r, a_hi_nxt;
  value_t                m_lo_r, m_lo_nxt, m_hi_r, m_hi_nxt;
  value_t                pend_lo_r, pend_lo_nxt, pend_hi_r, pend_hi_nxt;
  logic                  covered_r, covered_nxt;
  logic                  placed_r, placed_nxt;
  logic                  hit_r, hit_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  value_t                res_lo_r, res_lo_nxt, res_hi_r, res_hi_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [RCOUNT_W-1:0]   out_count_r, out_count_nxt;
  value_t                out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic                  out_hit_r, out_hit_nxt;

  value_t                lo_mem [MEM_DEPTH];
  value_t                hi_mem [MEM_DEPTH];
  value_t                rd_lo_r, rd_hi_r;
  logic [IDX_W:0]        rd_addr, wr_addr;
  logic                  wr_en;
  value_t                wr_lo, wr_hi;

  value_t                in_lo, in_hi;
  logic [CMP_W-1:0]      idx_w, cnt_w;
  logic                  last_entry;

  function automatic logic overlaps(value_t alo, value_t ahi, value_t blo, value_t bhi);
    return (alo <= bhi) && (blo <= ahi);
  endfunction

  // Overlap, or adjacency without wrapping at the top of the value range.
  function automatic logic touches(value_t alo, value_t ahi, value_t blo, value_t bhi);
    logic adj_ab, adj_ba;
    adj_ab = (ahi < blo) && (({1'b0, ahi} + 1'b1) == {1'b0, blo});
    adj_ba = (bhi < alo) && (({1'b0, bhi} + 1'b1) == {1'b0, alo});
    return overlaps(alo, ahi, blo, bhi) || adj_ab || adj_ba;
  endfunction

  assign in_lo = (in_range_high[VW-1:0] < in_range_low[VW-1:0]) ?
                 in_range_high[VW-1:0] : in_range_low[VW-1:0];
  assign in_hi = (in_range_high[VW-1:0] < in_range_low[VW-1:0]) ?
                 in_range_low[VW-1:0] : in_range_high[VW-1:0];
  assign idx_w = CMP_W'(in_entry_index);
  assign cnt_w = CMP_W'(count_r);
  assign last_entry = ((NW'(i_r) + 1'b1) == count_r);

  assign rd_addr = {bank_r, i_r};
  assign wr_addr = {~bank_r, n_r[IDX_W-1:0]};

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_range_count = out_count_r;
  assign out_entry_low   = FIELD_W'(out_lo_r);
  assign out_entry_high  = FIELD_W'(out_hi_r);
  assign out_hit         = out_hit_r;

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    phase_nxt      = phase_r;
    i_nxt          = i_r;
    n_nxt          = n_r;
    a_lo_nxt       = a_lo_r;
    a_hi_nxt       = a_hi_r;
    m_lo_nxt       = m_lo_r;
    m_hi_nxt       = m_hi_r;
    pend_lo_nxt    = pend_lo_r;
    pend_hi_nxt    = pend_hi_r;
    covered_nxt    = covered_r;
    placed_nxt     = placed_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_lo_nxt     = res_lo_r;
    res_hi_nxt     = res_hi_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    out_hit_nxt    = out_hit_r;
    wr_en          = 1'b0;
    wr_lo          = '0;
    wr_hi          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_action;
          a_lo_nxt       = in_lo;
          a_hi_nxt       = in_hi;
          m_lo_nxt       = in_lo;
          m_hi_nxt       = in_hi;
          i_nxt          = '0;
          n_nxt          = '0;
          phase_nxt      = 1'b0;
          covered_nxt    = 1'b0;
          placed_nxt     = 1'b0;
          hit_nxt        = 1'b0;
          res_status_nxt = ST_OK;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          case (in_action) inside
            ACT_ADD, ACT_COVERS, ACT_OVERLAP: begin
              state_nxt = (count_r == '0) ? S_FIN : S_RD;
            end
            ACT_REMOVE: begin
              phase_nxt = 1'b1;
              state_nxt = (count_r == '0) ? S_FIN : S_RD;
            end
            ACT_READ: begin
              if (idx_w < cnt_w) begin
                i_nxt     = idx_w[IDX_W-1:0];
                state_nxt = S_RD;
              end else begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_RD: state_nxt = S_EX;

      S_EX: begin
        state_nxt = last_entry ? S_FIN : S_RD;
        i_nxt     = last_entry ? i_r : i_r + 1'b1;
        case (op_r)
          ACT_ADD: begin
            if (!phase_r) begin
              // Merge scan: cover test on the original range, growth of the merged one.
              if (rd_lo_r <= a_lo_r && a_hi_r <= rd_hi_r) covered_nxt = 1'b1;
              if (touches(rd_lo_r, rd_hi_r, m_lo_r, m_hi_r)) begin
                if (rd_lo_r < m_lo_r) m_lo_nxt = rd_lo_r;
                if (rd_hi_r > m_hi_r) m_hi_nxt = rd_hi_r;
              end
            end else if (!touches(rd_lo_r, rd_hi_r, m_lo_r, m_hi_r)) begin
              // Rebuild scan: ranges swallowed by the merge are dropped.
              wr_en = (n_r < NW'(CAPACITY));
              n_nxt = n_r + 1'b1;
              if (!placed_r && rd_lo_r > m_hi_r) begin
                wr_lo       = m_lo_r;
                wr_hi       = m_hi_r;
                placed_nxt  = 1'b1;
                pend_lo_nxt = rd_lo_r;
                pend_hi_nxt = rd_hi_r;
                state_nxt   = S_W2;
                i_nxt       = i_r;
              end else begin
                wr_lo = rd_lo_r;
                wr_hi = rd_hi_r;
              end
            end
          end
          ACT_REMOVE: begin
            wr_en = (n_r < NW'(CAPACITY));
            if (!overlaps(rd_lo_r, rd_hi_r, a_lo_r, a_hi_r)) begin
              wr_lo = rd_lo_r;
              wr_hi = rd_hi_r;
              n_nxt = n_r + 1'b1;
            end else if (rd_lo_r < a_lo_r) begin
              wr_lo = rd_lo_r;
              wr_hi = a_lo_r - 1'b1;
              n_nxt = n_r + 1'b1;
              if (rd_hi_r > a_hi_r) begin
                // A range split in two: the right leftover follows next cycle.
                pend_lo_nxt = a_hi_r + 1'b1;
                pend_hi_nxt = rd_hi_r;
                state_nxt   = S_W2;
                i_nxt       = i_r;
              end
            end else if (rd_hi_r > a_hi_r) begin
              wr_lo = a_hi_r + 1'b1;
              wr_hi = rd_hi_r;
              n_nxt = n_r + 1'b1;
            end else begin
              wr_en = 1'b0;
            end
          end
          ACT_READ: begin
            res_lo_nxt = rd_lo_r;
            res_hi_nxt = rd_hi_r;
            state_nxt  = S_DONE;
          end
          ACT_COVERS: begin
            if (rd_lo_r <= a_lo_r && a_hi_r <= rd_hi_r) hit_nxt = 1'b1;
          end
          ACT_OVERLAP: begin
            if (overlaps(rd_lo_r, rd_hi_r, a_lo_r, a_hi_r)) hit_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      S_W2: begin
        wr_en     = (n_r < NW'(CAPACITY));
        wr_lo     = pend_lo_r;
        wr_hi     = pend_hi_r;
        n_nxt     = n_r + 1'b1;
        state_nxt = last_entry ? S_FIN : S_RD;
        i_nxt     = last_entry ? i_r : i_r + 1'b1;
      end

      S_FIN: begin
        state_nxt = S_DONE;
        case (op_r)
          ACT_ADD: begin
            if (!phase_r) begin
              if (!covered_r) begin
                phase_nxt = 1'b1;
                i_nxt     = '0;
                state_nxt = (count_r == '0) ? S_FIN : S_RD;
              end
            end else begin
              if (!placed_r) begin
                wr_en = (n_r < NW'(CAPACITY));
                wr_lo = m_lo_r;
                wr_hi = m_hi_r;
              end
              if ((n_r + NW'(!placed_r)) > NW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                bank_nxt  = ~bank_r;
                count_nxt = n_r + NW'(!placed_r);
              end
            end
          end
          ACT_REMOVE: begin
            if (n_r > NW'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else begin
              bank_nxt  = ~bank_r;
              count_nxt = n_r;
            end
          end
          default: ;
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = RCOUNT_W'(count_r);
          out_lo_nxt     = res_lo_r;
          out_hi_nxt     = res_hi_r;
          out_hit_nxt    = hit_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    phase_r      <= phase_nxt;
    i_r          <= i_nxt;
    n_r          <= n_nxt;
    a_lo_r       <= a_lo_nxt;
    a_hi_r       <= a_hi_nxt;
    m_lo_r       <= m_lo_nxt;
    m_hi_r       <= m_hi_nxt;
    pend_lo_r    <= pend_lo_nxt;
    pend_hi_r    <= pend_hi_nxt;
    covered_r    <= covered_nxt;
    placed_r     <= placed_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_lo_r     <= res_lo_nxt;
    res_hi_r     <= res_hi_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
    out_hit_r    <= out_hit_nxt;
  end

  // Range memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[wr_addr] <= wr_lo;
      hi_mem[wr_addr] <= wr_hi;
    end
    rd_lo_r <= lo_mem[rd_addr];
    rd_hi_r <= hi_mem[rd_addr];
  end

endmodule

@@ hw/rtl/ise_checker.sv @@
`include "interval_set_engine_assert.svh"

module ise_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ise_pkg::STATUS_W-1:0]   out_status,
  input logic [ise_pkg::RCOUNT_W-1:0]   out_range_count,
  input logic [ise_pkg::FIELD_W-1:0]    out_entry_low,
  input logic [ise_pkg::FIELD_W-1:0]    out_entry_high,
  input logic                           out_hit
);
  import ise_pkg::*;

  // A waiting result is not withdrawn.
  `ISE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // Once an item is taken the block is busy with it.
  `ISE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // The reported count never exceeds the capacity.
  `ISE_ASSERT_NOW(a_count_bound, out_valid, out_range_count <= RCOUNT_W'(CAPACITY))
  // A refused read returns zero bounds.
  `ISE_ASSERT_NOW(a_range_zero, out_valid && out_status == ST_RANGE,
                  out_entry_low == '0 && out_entry_high == '0 && !out_hit)

endmodule

bind interval_set_engine ise_checker u_ise_checker (.*);
